>>> rtl/ttss_pkg.sv
// ----------------------------------------------------------------------------
// ttss_pkg
// shared types, codes and constants of the timed task slot scheduler
// ----------------------------------------------------------------------------
package ttss_pkg;

    // table size default and per-tick result limit
    localparam int unsigned SLOTS_DEF   = 16;
    localparam int unsigned MAX_RESULTS = 16;

    // field widths
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned TASK_W = 8;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned CFGI_W = 1;
    localparam int unsigned CFGD_W = 32;

    // config reset values and register indexes
    localparam logic [TIME_W-1:0] MAX_LAG_RST = 32'd1000;
    localparam logic [CFGI_W-1:0] CFG_LAG_EN  = 1'd0;
    localparam logic [CFGI_W-1:0] CFG_MAX_LAG = 1'd1;

    // repeat count meaning endless
    localparam logic signed [CNT_W-1:0] CNT_ENDLESS = -16'sd1;
    localparam logic signed [CNT_W-1:0] CNT_ZERO    = 16'sd0;

    typedef enum logic [ACT_W-1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_CLEAR    = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_SCHEDULED = 3'd0,
        ST_FULL      = 3'd1,
        ST_FIRED     = 3'd2,
        ST_NONE_DUE  = 3'd3,
        ST_CLEARED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_FLUSH
    } t_state;

    // one slot entry as kept in the slot memory
    typedef struct packed {
        logic [TASK_W-1:0]        tsk_id;
        logic [TIME_W-1:0]        due;
        logic                     repeats;
        logic [TIME_W-1:0]        interval;
        logic signed [CNT_W-1:0]  count;
    } t_slot_rec;

    localparam int unsigned REC_W = $bits(t_slot_rec);

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the request fields
        logic clear;     // drop every slot, report cleared
        logic sched_wr;  // write request into the slot at the search index
        logic full;      // report table full
        logic rd;        // read the slot at the scan index
        logic eval;      // slot read last cycle is checked
        logic flush;     // report final tick result
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic idx_active;  // slot at search index is in use
        logic fire;        // slot under check is due
    } t_dp_stat;

endpackage

>>> rtl/ttss_ram.sv
// ----------------------------------------------------------------------------
// ttss_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ttss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ttss_ctrl.sv
// ----------------------------------------------------------------------------
// ttss_ctrl
// sequencer for slot search, tick scan and final result
// ----------------------------------------------------------------------------
module ttss_ctrl #(
    parameter int unsigned SLOTS = ttss_pkg::SLOTS_DEF,
    parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ttss_pkg::ACT_W-1:0]     i_action,
    output logic                           o_busy,
    input  ttss_pkg::t_dp_stat             i_stat,
    output ttss_pkg::t_ctl_cmd             o_cmd,
    output logic [IW-1:0]                  o_idx,
    output logic [IW-1:0]                  o_ev_idx
);

    localparam int unsigned FCW = $clog2(ttss_pkg::MAX_RESULTS + 1);
    localparam logic [IW-1:0]  LAST_IDX  = IW'(SLOTS - 1);
    localparam logic [FCW-1:0] LAST_FIRE = FCW'(ttss_pkg::MAX_RESULTS - 1);

    ttss_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_ev_idx, n_ev_idx;
    logic             r_ev_vld, n_ev_vld;
    logic             r_rd_left, n_rd_left;
    logic [FCW-1:0]   r_fcnt, n_fcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ttss_pkg::S_IDLE;
            r_idx     <= '0;
            r_ev_idx  <= '0;
            r_ev_vld  <= 1'b0;
            r_rd_left <= 1'b0;
            r_fcnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_ev_idx  <= n_ev_idx;
            r_ev_vld  <= n_ev_vld;
            r_rd_left <= n_rd_left;
            r_fcnt    <= n_fcnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_ev_idx  = r_ev_idx;
        n_ev_vld  = 1'b0;
        n_rd_left = r_rd_left;
        n_fcnt    = r_fcnt;
        o_cmd     = '0;

        case (r_state)
            ttss_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        ttss_pkg::ACT_SCHEDULE: begin
                            n_idx   = '0;
                            n_state = ttss_pkg::S_FIND;
                        end
                        ttss_pkg::ACT_TICK: begin
                            n_idx     = '0;
                            n_rd_left = 1'b1;
                            n_fcnt    = '0;
                            n_state   = ttss_pkg::S_SCAN;
                        end
                        ttss_pkg::ACT_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ttss_pkg::S_FIND: begin
                // one slot per cycle, lowest free slot wins
                if (!i_stat.idx_active) begin
                    o_cmd.sched_wr = 1'b1;
                    n_state        = ttss_pkg::S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    o_cmd.full = 1'b1;
                    n_state    = ttss_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            ttss_pkg::S_SCAN: begin
                // read stage
                if (r_rd_left) begin
                    o_cmd.rd = 1'b1;
                    n_ev_vld = 1'b1;
                    n_ev_idx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_rd_left = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                // check stage
                if (r_ev_vld) begin
                    o_cmd.eval = 1'b1;
                    if (i_stat.fire) begin
                        n_fcnt = r_fcnt + FCW'(1);
                    end
                    if ((i_stat.fire && r_fcnt == LAST_FIRE) || r_ev_idx == LAST_IDX) begin
                        n_ev_vld  = 1'b0;
                        n_rd_left = 1'b0;
                        n_state   = ttss_pkg::S_FLUSH;
                    end
                end
            end

            ttss_pkg::S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ttss_pkg::S_IDLE;
            end

            default: begin
                n_state = ttss_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != ttss_pkg::S_IDLE);
    assign o_idx    = r_idx;
    assign o_ev_idx = r_ev_idx;

endmodule

>>> rtl/ttss_dp.sv
// ----------------------------------------------------------------------------
// ttss_dp
// slot table, config registers, due check and result registers
// ----------------------------------------------------------------------------
module ttss_dp #(
    parameter int unsigned SLOTS = ttss_pkg::SLOTS_DEF,
    parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ttss_pkg::t_ctl_cmd                  i_cmd,
    output ttss_pkg::t_dp_stat                  o_stat,
    input  logic [IW-1:0]                       i_idx,
    input  logic [IW-1:0]                       i_ev_idx,
    input  logic [ttss_pkg::TASK_W-1:0]         i_task_id,
    input  logic [ttss_pkg::TIME_W-1:0]         i_trigger_time,
    input  logic                                i_repeat_req,
    input  logic [ttss_pkg::TIME_W-1:0]         i_repeat_interval,
    input  logic signed [ttss_pkg::CNT_W-1:0]   i_remaining_repeats,
    input  logic [ttss_pkg::TIME_W-1:0]         i_now,
    input  logic                                i_cfg_valid,
    input  logic [ttss_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [ttss_pkg::CFGD_W-1:0]         i_cfg_data,
    output logic                                o_strobe,
    output logic [ttss_pkg::STAT_W-1:0]         o_status,
    output logic [ttss_pkg::SLOT_W-1:0]         o_slot,
    output logic [ttss_pkg::TASK_W-1:0]         o_fired_task,
    output logic                                o_finished,
    output logic                                o_lagging,
    output logic                                o_last
);

    // config
    logic                          r_lag_en;
    logic [ttss_pkg::TIME_W-1:0]   r_max_lag;

    // latched request
    logic [ttss_pkg::TASK_W-1:0]        r_in_task;
    logic [ttss_pkg::TIME_W-1:0]        r_in_trig;
    logic                               r_in_rep;
    logic [ttss_pkg::TIME_W-1:0]        r_in_intv;
    logic signed [ttss_pkg::CNT_W-1:0]  r_in_cnt;
    logic [ttss_pkg::TIME_W-1:0]        r_in_now;

    logic [SLOTS-1:0] r_active;

    // fired result waiting to learn whether it is the final one
    logic                          r_hold_vld;
    logic [ttss_pkg::SLOT_W-1:0]   r_hold_slot;
    logic [ttss_pkg::TASK_W-1:0]   r_hold_task;
    logic                          r_hold_fin;
    logic                          r_hold_lag;

    // result registers
    logic                          r_strobe;
    logic [ttss_pkg::STAT_W-1:0]   r_status, n_status;
    logic [ttss_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic [ttss_pkg::TASK_W-1:0]   r_ftask, n_ftask;
    logic                          r_fin, n_fin;
    logic                          r_lag, n_lag;
    logic                          r_last, n_last;
    logic                          n_strobe;

    // memory side
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [ttss_pkg::REC_W-1:0]    ram_wdata;
    logic [ttss_pkg::REC_W-1:0]    ram_rdata;

    ttss_pkg::t_slot_rec           rec_new, rec_rd, rec_upd;
    logic [ttss_pkg::TIME_W-1:0]   late;
    logic                          hit;
    logic                          lag;
    logic                          fin;
    logic                          fire_now;

    ttss_ram #(
        .WIDTH (ttss_pkg::REC_W),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (i_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // counts below endless are stored as endless
        rec_new.tsk_id   = r_in_task;
        rec_new.due      = r_in_trig;
        rec_new.repeats  = r_in_rep;
        rec_new.interval = r_in_intv;
        rec_new.count    = (r_in_cnt < ttss_pkg::CNT_ENDLESS) ? ttss_pkg::CNT_ENDLESS
                                                                : r_in_cnt;

        rec_rd = ttss_pkg::t_slot_rec'(ram_rdata);
        hit    = r_active[i_ev_idx] && (rec_rd.due <= r_in_now);
        late   = r_in_now - rec_rd.due;
        lag    = r_lag_en && (rec_rd.due != '0) && (late >= r_max_lag);

        // rearm or retire
        rec_upd = rec_rd;
        fin     = 1'b1;
        if (rec_rd.repeats) begin
            rec_upd.due = r_in_now + rec_rd.interval;
            if (rec_rd.count != ttss_pkg::CNT_ZERO) begin
                fin = 1'b0;
                if (rec_rd.count != ttss_pkg::CNT_ENDLESS) begin
                    rec_upd.count = rec_rd.count - ttss_pkg::CNT_W'(1);
                end
            end
        end

        fire_now = i_cmd.eval && hit;

        ram_we    = 1'b0;
        ram_waddr = i_idx;
        ram_wdata = rec_new;
        if (i_cmd.sched_wr) begin
            ram_we = 1'b1;
        end else if (fire_now) begin
            ram_we    = 1'b1;
            ram_waddr = i_ev_idx;
            ram_wdata = rec_upd;
        end

        n_strobe = 1'b0;
        n_status = r_status;
        n_slot   = r_slot;
        n_ftask  = r_ftask;
        n_fin    = r_fin;
        n_lag    = r_lag;
        n_last   = r_last;
        if (i_cmd.clear || i_cmd.sched_wr || i_cmd.full) begin
            n_strobe = 1'b1;
            n_slot   = '0;
            n_ftask  = '0;
            n_fin    = 1'b0;
            n_lag    = 1'b0;
            n_last   = 1'b1;
            if (i_cmd.clear) begin
                n_status = ttss_pkg::ST_CLEARED;
            end else if (i_cmd.sched_wr) begin
                n_status = ttss_pkg::ST_SCHEDULED;
                n_slot   = ttss_pkg::SLOT_W'(i_idx);
            end else begin
                n_status = ttss_pkg::ST_FULL;
            end
        end else if ((fire_now && r_hold_vld) || i_cmd.flush) begin
            // older fired result goes out, final one only on flush
            n_strobe = 1'b1;
            n_last   = i_cmd.flush;
            if (r_hold_vld) begin
                n_status = ttss_pkg::ST_FIRED;
                n_slot   = r_hold_slot;
                n_ftask  = r_hold_task;
                n_fin    = r_hold_fin;
                n_lag    = r_hold_lag;
            end else begin
                n_status = ttss_pkg::ST_NONE_DUE;
                n_slot   = '0;
                n_ftask  = '0;
                n_fin    = 1'b0;
                n_lag    = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_en   <= 1'b0;
            r_max_lag  <= ttss_pkg::MAX_LAG_RST;
            r_active   <= '0;
            r_hold_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ttss_pkg::CFG_LAG_EN:  r_lag_en  <= i_cfg_data[0];
                    ttss_pkg::CFG_MAX_LAG: r_max_lag <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.clear) begin
                r_active <= '0;
            end else if (i_cmd.sched_wr) begin
                r_active[i_idx] <= 1'b1;
            end else if (fire_now && fin) begin
                r_active[i_ev_idx] <= 1'b0;
            end

            if (i_cmd.load || i_cmd.flush) begin
                r_hold_vld <= 1'b0;
            end else if (fire_now) begin
                r_hold_vld <= 1'b1;
            end

            r_strobe <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_task <= i_task_id;
            r_in_trig <= i_trigger_time;
            r_in_rep  <= i_repeat_req;
            r_in_intv <= i_repeat_interval;
            r_in_cnt  <= i_remaining_repeats;
            r_in_now  <= i_now;
        end
        if (fire_now) begin
            r_hold_slot <= ttss_pkg::SLOT_W'(i_ev_idx);
            r_hold_task <= rec_rd.tsk_id;
            r_hold_fin  <= fin;
            r_hold_lag  <= lag;
        end
        r_status <= n_status;
        r_slot   <= n_slot;
        r_ftask  <= n_ftask;
        r_fin    <= n_fin;
        r_lag    <= n_lag;
        r_last   <= n_last;
    end

    assign o_stat.idx_active = r_active[i_idx];
    assign o_stat.fire       = hit;

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_fired_task = r_ftask;
    assign o_finished   = r_fin;
    assign o_lagging    = r_lag;
    assign o_last       = r_last;

endmodule

>>> rtl/timed_task_slot_scheduler_core.sv
// ----------------------------------------------------------------------------
// timed_task_slot_scheduler_core
// table of timed task slots: schedule, tick scan with firing, clear all
// ----------------------------------------------------------------------------
// clear: one result on the cycle after the request, block stays free
// schedule: one slot checked per cycle, result once a free slot or the last slot is reached
// tick: slot memory read one slot per cycle; the scan ends after the last slot
//   or at MAX_RESULTS firings, then the flush state follows; fired results
//   stream out during the scan, the final one from the flush state; busy till then
// receiver cannot stall: every result shows on the outputs for one cycle
// reset (synchronous, active low) empties the table and restores max lag 1000
module timed_task_slot_scheduler_core #(
    parameter int unsigned SLOTS = ttss_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic [ttss_pkg::ACT_W-1:0]          i_action,
    input  logic [ttss_pkg::TASK_W-1:0]         i_task_id,
    input  logic [ttss_pkg::TIME_W-1:0]         i_trigger_time,
    input  logic                                i_repeat_req,
    input  logic [ttss_pkg::TIME_W-1:0]         i_repeat_interval,
    input  logic signed [ttss_pkg::CNT_W-1:0]   i_remaining_repeats,
    input  logic [ttss_pkg::TIME_W-1:0]         i_now,

    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ttss_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [ttss_pkg::CFGD_W-1:0]         i_cfg_data,

    // result channel
    output logic                                o_strobe,
    output logic [ttss_pkg::STAT_W-1:0]         o_status,
    output logic [ttss_pkg::SLOT_W-1:0]         o_slot,
    output logic [ttss_pkg::TASK_W-1:0]         o_fired_task,
    output logic                                o_finished,
    output logic                                o_lagging,
    output logic                                o_last
);

    // slot index width, one bit minimum for a single-slot table
    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    ttss_pkg::t_ctl_cmd cmd;
    ttss_pkg::t_dp_stat stat;
    logic [IW-1:0]      idx;     // search / read index
    logic [IW-1:0]      ev_idx;  // slot whose data is out of the memory
    logic               ctl_busy;

    // a request is taken only while the sequencer is idle
    logic               req_go;
    assign req_go = start && !ctl_busy;

    ttss_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (req_go),
        .i_action (i_action),
        .o_busy   (ctl_busy),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_idx    (idx),
        .o_ev_idx (ev_idx)
    );

    ttss_dp #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_idx               (idx),
        .i_ev_idx            (ev_idx),
        .i_task_id           (i_task_id),
        .i_trigger_time      (i_trigger_time),
        .i_repeat_req        (i_repeat_req),
        .i_repeat_interval   (i_repeat_interval),
        .i_remaining_repeats (i_remaining_repeats),
        .i_now               (i_now),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_slot              (o_slot),
        .o_fired_task        (o_fired_task),
        .o_finished          (o_finished),
        .o_lagging           (o_lagging),
        .o_last              (o_last)
    );

    // config registers take a write in any cycle
    assign o_cfg_ready = 1'b1;
    assign busy        = ctl_busy;

endmodule

>>> tb/sv/timed_task_slot_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// timed_task_slot_scheduler_core_tb
// self-checking bench for the timed task slot scheduler: a short directed
// table (empty table, unused action, field extremes, full table, scan once,
// count below -1, retire at count zero, endless repeats, time wrap, clear)
// followed by random phases under several lag settings; every accepted
// request is run through a local copy of the slot table and the results on
// the strobe are compared with the oldest expected ones
// ----------------------------------------------------------------------------
module timed_task_slot_scheduler_core_tb;
    import ttss_pkg::*;

    localparam int unsigned NSLOT        = SLOTS_DEF;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;   // no result, no change
    localparam int unsigned GAP_MAX      = 16;
    localparam int unsigned DRAIN_CYCLES = NSLOT + 8;  // longer than one tick scan
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned PHASE_ITEMS  = 41;
    localparam int unsigned PHASES       = 5;

    // one request as presented on the input ports
    typedef struct packed {
        logic [ACT_W-1:0]         act;
        logic [TASK_W-1:0]        tid;
        logic [TIME_W-1:0]        trig;
        logic                     rep;
        logic [TIME_W-1:0]        intv;
        logic signed [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0]        tnow;
    } t_req;

    // one result as seen on the strobe
    typedef struct packed {
        t_status            st;
        logic [SLOT_W-1:0]  slot;
        logic [TASK_W-1:0]  tid;
        logic               fin;
        logic               lag;
        logic               last;
    } t_outcome;

    // directed row: a request plus an optional single result typed in by hand
    typedef struct packed {
        t_req               req;
        logic               typed;
        t_status            st;
        logic [SLOT_W-1:0]  slot;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [ACT_W-1:0]            i_action;
    logic [TASK_W-1:0]           i_task_id;
    logic [TIME_W-1:0]           i_trigger_time;
    logic                        i_repeat_req;
    logic [TIME_W-1:0]           i_repeat_interval;
    logic signed [CNT_W-1:0]     i_remaining_repeats;
    logic [TIME_W-1:0]           i_now;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFGI_W-1:0]           i_cfg_index;
    logic [CFGD_W-1:0]           i_cfg_data;
    logic                        o_strobe;
    logic [STAT_W-1:0]           o_status;
    logic [SLOT_W-1:0]           o_slot;
    logic [TASK_W-1:0]           o_fired_task;
    logic                        o_finished;
    logic                        o_lagging;
    logic                        o_last;

    // hand-typed expectation travels with the request it belongs to
    logic                        fixed_on;
    t_status                     fixed_st;
    logic [SLOT_W-1:0]           fixed_slot;

    // local copy of the slot table and the lag registers
    logic                        tbl_on   [NSLOT];
    logic [TASK_W-1:0]           tbl_task [NSLOT];
    logic [TIME_W-1:0]           tbl_due  [NSLOT];
    logic                        tbl_rearm[NSLOT];
    logic [TIME_W-1:0]           tbl_gap  [NSLOT];
    logic signed [CNT_W-1:0]     tbl_left [NSLOT];
    logic                        lag_on;
    logic [TIME_W-1:0]           lag_limit;

    t_outcome                    fresh_results[$];
    t_outcome                    pending_results[$];
    int unsigned                 err_cnt = 0;
    int unsigned                 stall_cycles = 0;
    logic                        steady = 1'b0;     // no gaps while set
    logic [TIME_W-1:0]           sim_now = '0;      // time base for random ticks

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    timed_task_slot_scheduler_core #(
        .SLOTS(NSLOT)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_task_id           (i_task_id),
        .i_trigger_time      (i_trigger_time),
        .i_repeat_req        (i_repeat_req),
        .i_repeat_interval   (i_repeat_interval),
        .i_remaining_repeats (i_remaining_repeats),
        .i_now               (i_now),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_slot              (o_slot),
        .o_fired_task        (o_fired_task),
        .o_finished          (o_finished),
        .o_lagging           (o_lagging),
        .o_last              (o_last)
    );

    // ------------------------------------------------------------------------
    // slot table prediction: fills fresh_results with what one request causes
    // ------------------------------------------------------------------------
    function automatic void scheduler_predict(input t_req r);
        int          hit;
        int unsigned n;
        logic        lag;
        logic        fin;
        t_outcome    o;
        fresh_results.delete();
        hit = -1;
        n   = 0;
        case (r.act)
            ACT_SCHEDULE: begin
                // lowest free slot wins
                for (int i = 0; i < NSLOT; i++)
                    if (!tbl_on[i] && hit < 0) hit = i;
                o = '0;
                if (hit < 0) begin
                    o.st = ST_FULL;
                end else begin
                    tbl_on[hit]    = 1'b1;
                    tbl_task[hit]  = r.tid;
                    tbl_due[hit]   = r.trig;
                    tbl_rearm[hit] = r.rep;
                    tbl_gap[hit]   = r.intv;
                    // any count below endless is kept as endless
                    tbl_left[hit]  = ($signed(r.cnt) < $signed(CNT_ENDLESS)) ? CNT_ENDLESS
                                                                            : r.cnt;
                    o.st   = ST_SCHEDULED;
                    o.slot = SLOT_W'(hit);
                end
                fresh_results.push_back(o);
            end
            ACT_TICK: begin
                // each slot looked at once per tick, so a rearm at now waits
                for (int i = 0; i < NSLOT && n < MAX_RESULTS; i++) begin
                    if (tbl_on[i] && tbl_due[i] <= r.tnow) begin
                        lag = lag_on && (tbl_due[i] != '0) &&
                              ((r.tnow - tbl_due[i]) >= lag_limit);
                        fin = 1'b0;
                        if (tbl_rearm[i]) begin
                            tbl_due[i] = r.tnow + tbl_gap[i];   // wraps mod 2^32
                            if (tbl_left[i] == CNT_ZERO) begin
                                tbl_on[i] = 1'b0;
                                fin       = 1'b1;
                            end else if (tbl_left[i] != CNT_ENDLESS) begin
                                tbl_left[i] = tbl_left[i] - 16'sd1;
                            end
                        end else begin
                            tbl_on[i] = 1'b0;
                            fin       = 1'b1;
                        end
                        o      = '0;
                        o.st   = ST_FIRED;
                        o.slot = SLOT_W'(i);
                        o.tid  = tbl_task[i];
                        o.fin  = fin;
                        o.lag  = lag;
                        fresh_results.push_back(o);
                        n++;
                    end
                end
                if (n == 0) begin
                    o    = '0;
                    o.st = ST_NONE_DUE;
                    fresh_results.push_back(o);
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) tbl_on[i] = 1'b0;
                o    = '0;
                o.st = ST_CLEARED;
                fresh_results.push_back(o);
            end
            default: ;  // unused action: nothing happens
        endcase
        if (fresh_results.size() != 0)
            fresh_results[fresh_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(input string what, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: results first, then the request taken at this edge, then config
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome want;
        t_req     seen;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                             $time, o_status, o_slot);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.st, o_status);
                    check_field("slot", want.slot, o_slot);
                    check_field("fired_task", want.tid, o_fired_task);
                    check_field("finished", want.fin, o_finished);
                    check_field("lagging", want.lag, o_lagging);
                    check_field("last", want.last, o_last);
                end
            end
            if (start && busy === 1'b0) begin
                seen.act  = i_action;
                seen.tid  = i_task_id;
                seen.trig = i_trigger_time;
                seen.rep  = i_repeat_req;
                seen.intv = i_repeat_interval;
                seen.cnt  = i_remaining_repeats;
                seen.tnow = i_now;
                // table state always follows the prediction, even for typed rows
                scheduler_predict(seen);
                if (fixed_on) begin
                    want      = '0;
                    want.st   = fixed_st;
                    want.slot = fixed_slot;
                    want.last = 1'b1;
                    pending_results.push_back(want);
                end else begin
                    foreach (fresh_results[k]) pending_results.push_back(fresh_results[k]);
                end
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                if (i_cfg_index == CFG_LAG_EN)
                    lag_on = i_cfg_data[0];
                else if (i_cfg_index == CFG_MAX_LAG)
                    lag_limit = i_cfg_data;
            end
        end
    end

    // watchdog: too long with no request, result or config write taken
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver side
    // ------------------------------------------------------------------------

    // present one request after a random gap and hold it until taken;
    // start stays high when the next gap is zero
    task automatic issue(input t_req r, input logic typed, input t_status st,
                         input logic [SLOT_W-1:0] slot);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start               <= 1'b1;
        i_action            <= r.act;
        i_task_id           <= r.tid;
        i_trigger_time      <= r.trig;
        i_repeat_req        <= r.rep;
        i_repeat_interval   <= r.intv;
        i_remaining_repeats <= r.cnt;
        i_now               <= r.tnow;
        fixed_on            <= typed;
        fixed_st            <= st;
        fixed_slot          <= slot;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // both registers in one burst, valid held high across the two writes
    task automatic program_regs(input logic en, input logic [TIME_W-1:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LAG_EN;
        i_cfg_data  <= {{(CFGD_W-1){1'b0}}, en};
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_index <= CFG_MAX_LAG;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    // stop requesting, let every expected result arrive, then let a
    // possible silent request finish
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_row dir_row(input logic [ACT_W-1:0] act, input logic [TASK_W-1:0] tid,
                                     input logic [TIME_W-1:0] trig, input logic rep,
                                     input logic [TIME_W-1:0] intv,
                                     input logic signed [CNT_W-1:0] cnt,
                                     input logic [TIME_W-1:0] tnow, input logic typed,
                                     input t_status st, input logic [SLOT_W-1:0] slot);
        t_row w;
        w.req.act  = act;
        w.req.tid  = tid;
        w.req.trig = trig;
        w.req.rep  = rep;
        w.req.intv = intv;
        w.req.cnt  = cnt;
        w.req.tnow = tnow;
        w.typed    = typed;
        w.st       = st;
        w.slot     = slot;
        return w;
    endfunction

    // random request: mostly schedules near the running time and ticks that
    // walk it forward, a little noise from full-range values, clears and the
    // unused action
    function automatic t_req random_request(input int unsigned sched_pct);
        t_req        r;
        int unsigned pick;
        r.act  = ACT_W'($urandom_range(0, 3));
        r.tid  = TASK_W'($urandom);
        r.trig = $urandom;
        r.rep  = 1'($urandom);
        r.intv = $urandom;
        r.cnt  = CNT_W'($urandom);
        r.tnow = $urandom;
        pick   = $urandom_range(0, 99);
        if (pick < sched_pct) begin
            r.act = ACT_SCHEDULE;
            if ($urandom_range(0, 9) != 0) r.trig = sim_now + $urandom_range(0, 300);
            if ($urandom_range(0, 9) != 0) r.intv = $urandom_range(0, 120);
            if ($urandom_range(0, 7) != 0) r.cnt  = CNT_W'(int'($urandom_range(0, 6)) - 1);
        end else if (pick < 94) begin
            r.act   = ACT_TICK;
            sim_now = sim_now + $urandom_range(0, 150);
            if ($urandom_range(0, 15) != 0) r.tnow = sim_now;
        end else if (pick < 97) begin
            r.act = ACT_CLEAR;
        end else begin
            r.act = ACT_UNUSED;
        end
        return r;
    endfunction

    initial begin
        t_row        plan[$];
        logic        en;
        logic [TIME_W-1:0] lim;
        int unsigned sched_pct;

        // table empty and registers at reset values
        lag_on    = 1'b0;
        lag_limit = MAX_LAG_RST;
        for (int i = 0; i < NSLOT; i++) tbl_on[i] = 1'b0;

        i_rst_n             <= 1'b0;
        start               <= 1'b0;
        i_action            <= ACT_SCHEDULE;
        i_task_id           <= '0;
        i_trigger_time      <= '0;
        i_repeat_req        <= 1'b0;
        i_repeat_interval   <= '0;
        i_remaining_repeats <= '0;
        i_now               <= '0;
        i_cfg_valid         <= 1'b0;
        i_cfg_index         <= CFG_LAG_EN;
        i_cfg_data          <= '0;
        fixed_on            <= 1'b0;
        fixed_st            <= ST_SCHEDULED;
        fixed_slot          <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs(1'b1, MAX_LAG_RST);

        // ---- directed table ----
        // empty table: a tick finds nothing
        plan.push_back(dir_row(ACT_TICK, 8'h00, '0, 1'b0, '0, '0, '0,
                               1'b1, ST_NONE_DUE, '0));
        // unused action with every field at its top value
        plan.push_back(dir_row(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                               16'hFFFF, 32'hFFFF_FFFF, 1'b0, ST_SCHEDULED, '0));
        // one-shot due at time zero
        plan.push_back(dir_row(ACT_SCHEDULE, 8'hFF, '0, 1'b0, '0, '0, '0,
                               1'b1, ST_SCHEDULED, 4'd0));
        // endless repeat at the top of time with the widest interval
        plan.push_back(dir_row(ACT_SCHEDULE, 8'h00, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                               CNT_ENDLESS, '0, 1'b1, ST_SCHEDULED, 4'd1));
        // most negative count, zero interval so the rearm lands on now
        plan.push_back(dir_row(ACT_SCHEDULE, 8'h5A, 32'd100, 1'b1, '0, 16'h8000, '0,
                               1'b1, ST_SCHEDULED, 4'd2));
        // largest count
        plan.push_back(dir_row(ACT_SCHEDULE, 8'hA5, 32'd5, 1'b1, 32'd10, 16'h7FFF, '0,
                               1'b1, ST_SCHEDULED, 4'd3));
        // repeating with count zero retires on its first firing
        plan.push_back(dir_row(ACT_SCHEDULE, 8'h07, 32'd50, 1'b1, 32'd1, CNT_ZERO, '0,
                               1'b1, ST_SCHEDULED, 4'd4));
        // one repeat left, due exactly at the coming tick
        plan.push_back(dir_row(ACT_SCHEDULE, 8'h09, 32'd2000, 1'b1, '0, 16'sd1, '0,
                               1'b1, ST_SCHEDULED, 4'd5));
        // fill the rest of the table with later one-shots and repeats
        for (int k = 6; k < NSLOT; k++)
            plan.push_back(dir_row(ACT_SCHEDULE, TASK_W'(8'h10 + k), 32'd3000,
                                   1'($urandom), $urandom, CNT_W'($urandom), $urandom,
                                   1'b1, ST_SCHEDULED, SLOT_W'(k)));
        // table full: dropped
        plan.push_back(dir_row(ACT_SCHEDULE, 8'hEE, '0, 1'b1, 32'd5, 16'sd3, '0,
                               1'b1, ST_FULL, '0));
        // late firings with lag, due-zero without lag, rearm at now not refired
        plan.push_back(dir_row(ACT_TICK, '0, '0, 1'b0, '0, '0, 32'd2000,
                               1'b0, ST_SCHEDULED, '0));
        // same time again: the slots rearmed at now fire this time
        plan.push_back(dir_row(ACT_TICK, '0, '0, 1'b0, '0, '0, 32'd2000,
                               1'b0, ST_SCHEDULED, '0));
        plan.push_back(dir_row(ACT_SCHEDULE, 8'h3C, 32'd2500, 1'b1, 32'h8000_0000,
                               16'sd2, '0, 1'b0, ST_SCHEDULED, '0));
        // top of time: nearly every slot fires, rearm sums wrap
        plan.push_back(dir_row(ACT_TICK, '0, '0, 1'b0, '0, '0, 32'hFFFF_FFFF,
                               1'b0, ST_SCHEDULED, '0));
        plan.push_back(dir_row(ACT_CLEAR, '0, '0, 1'b0, '0, '0, '0,
                               1'b1, ST_CLEARED, '0));
        plan.push_back(dir_row(ACT_TICK, '0, '0, 1'b0, '0, '0, $urandom,
                               1'b1, ST_NONE_DUE, '0));
        foreach (plan[k]) issue(plan[k].req, plan[k].typed, plan[k].st, plan[k].slot);

        // ---- random phases, each under its own lag setting ----
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0:       begin en = 1'b1; lim = '0;                         end
                1:       begin en = 1'b1; lim = 32'hFFFF_FFFF;              end
                2:       begin en = 1'b0; lim = '0;                         end
                3:       begin en = 1'b1; lim = $urandom_range(0, 300);     end
                default: begin en = 1'b1; lim = $urandom;                   end
            endcase
            program_regs(en, lim);
            // third phase runs the time base across the 32-bit wrap
            if (p == 2) sim_now = 32'hFFFF_FE00;
            sched_pct = 40 + 5 * p;
            repeat (PHASE_ITEMS)
                issue(random_request(sched_pct), 1'b0, ST_SCHEDULED, '0);
        end

        settle();
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
